// File: hdl/cba_pkg.sv
package cba_pkg;

	typedef enum logic {
		KIND_ALLOC = 1'b0,
		KIND_FREE  = 1'b1
	} kind_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_UPDATE
	} state_t;

	typedef struct packed {
		logic       kind;
		logic [9:0] file_size;
		logic [8:0] start_index;
	} cmd_t;

	typedef struct packed {
		logic       ok;
		logic [8:0] alloc_start;
		logic [9:0] free_units;
		logic [8:0] wasted_units;
	} res_t;

endpackage

// File: hdl/cluster_bitmap_allocator_unit.sv
// Channel   Handshake               Word
// command   start / busy            cmd (kind, file_size, start_index)
// result    done, one-cycle strobe  result (ok, alloc_start, free_units, wasted_units)
//
// The bitmap lives in a ring of cells, one cluster word each, rotated past a head stage.
// An allocate makes two rotations: one to find the run, one to mark it and tally.
// A free makes one rotation to clear and tally. NC is the cluster count.
// Reset clears every unit to free. The receiver cannot stall: done is high one cycle.
module cluster_bitmap_allocator_unit #(
	parameter int TOTAL_UNITS   = 512,
	parameter int CLUSTER_UNITS = 8
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	input  cba_pkg::cmd_t cmd,
	output logic          done,
	output cba_pkg::res_t result
);

	import cba_pkg::*;

	localparam int NC      = (TOTAL_UNITS + CLUSTER_UNITS - 1) / CLUSTER_UNITS;
	localparam int CW      = (NC > 1) ? $clog2(NC) : 1;
	localparam int UW      = $clog2(TOTAL_UNITS + 2048) + 1;
	localparam int BW      = (CLUSTER_UNITS > 1) ? $clog2(CLUSTER_UNITS) : 1;
	localparam int LASTPOS = TOTAL_UNITS - 1 - (NC - 1) * CLUSTER_UNITS;

	localparam logic [CW-1:0] LAST_K   = CW'(NC - 1);
	localparam logic [UW-1:0] CU_U     = UW'(CLUSTER_UNITS);
	localparam logic [BW-1:0] LAST_B   = BW'(LASTPOS);
	localparam logic [BW-1:0] FULL_B   = BW'(CLUSTER_UNITS - 1);

	logic [CLUSTER_UNITS-1:0] chain [NC+1];
	logic                     shift;
	logic [CLUSTER_UNITS-1:0] head_w, new_w;

	genvar gi;
	generate
		for (gi = 0; gi < NC; gi++) begin : g_cell
			cba_cell #(.WIDTH(CLUSTER_UNITS)) u_cell (
				.clk       (clk),
				.arst_n    (arst_n),
				.shift     (shift),
				.next_word (chain[gi+1]),
				.word      (chain[gi])
			);
		end
	endgenerate

	state_t        state_q, state_n;
	cmd_t          cmd_q;
	logic [CW-1:0] k_q;
	logic [UW-1:0] base_q, run_q, rstart_q, start_u_q, free_q, waste_q;
	logic          found_q, done_q;
	res_t          result_q;

	logic [UW-1:0] size_u, run_n, lo, hi, u;
	logic [BW-1:0] lastpos, hib;
	logic          apply, last_k, hit;

	assign head_w = chain[0];
	assign last_k = (k_q == LAST_K);
	assign size_u = UW'(cmd_q.file_size);
	assign run_n  = head_w[0] ? '0 : run_q + CU_U;
	assign hit    = !found_q && !head_w[0] && (run_n >= size_u);

	assign lo      = (cmd_q.kind == KIND_FREE) ? UW'(cmd_q.start_index) : start_u_q;
	assign hi      = lo + size_u;
	assign apply   = (cmd_q.kind == KIND_FREE) || found_q;
	assign lastpos = last_k ? LAST_B : FULL_B;

	always_comb begin
		new_w = head_w;
		hib   = '0;
		u     = '0;
		for (int b = 0; b < CLUSTER_UNITS; b++) begin
			u = base_q + UW'(b);
			if (apply && (u >= lo) && (u < hi) && (BW'(b) <= lastpos)) begin
				new_w[b] = (cmd_q.kind == KIND_ALLOC);
			end
		end
		for (int b = 0; b < CLUSTER_UNITS; b++) begin
			if (new_w[b]) begin
				hib = BW'(b);
			end
		end
	end

	assign chain[NC] = (state_q == ST_SCAN) ? head_w : new_w;

	always_comb begin
		state_n = state_q;
		shift   = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					state_n = (cmd.kind == KIND_FREE) ? ST_UPDATE : ST_SCAN;
				end
			end
			ST_SCAN: begin
				shift = 1'b1;
				if (last_k) begin
					state_n = ST_UPDATE;
				end
			end
			ST_UPDATE: begin
				shift = 1'b1;
				if (last_k) begin
					state_n = ST_IDLE;
				end
			end
			default: state_n = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			done_q  <= 1'b0;
			k_q     <= '0;
			found_q <= 1'b0;
		end else begin
			state_q <= state_n;
			done_q  <= (state_q == ST_UPDATE) && last_k;
			case (state_q)
				ST_IDLE: begin
					k_q     <= '0;
					found_q <= 1'b0;
				end
				ST_SCAN: begin
					k_q <= last_k ? '0 : k_q + CW'(1);
					if (hit) begin
						found_q <= 1'b1;
					end
				end
				ST_UPDATE: begin
					k_q <= last_k ? '0 : k_q + CW'(1);
				end
				default: k_q <= '0;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				cmd_q     <= cmd;
				base_q    <= '0;
				run_q     <= '0;
				rstart_q  <= '0;
				start_u_q <= '0;
				free_q    <= '0;
				waste_q   <= '0;
			end
			ST_SCAN: begin
				run_q  <= run_n;
				base_q <= last_k ? '0 : base_q + CU_U;
				if (!head_w[0] && (run_q == '0)) begin
					rstart_q <= base_q;
				end
				if (hit) begin
					start_u_q <= (run_q == '0) ? base_q : rstart_q;
				end
			end
			ST_UPDATE: begin
				base_q <= base_q + CU_U;
				if (!new_w[0]) begin
					free_q <= free_q + CU_U;
				end else if (!new_w[lastpos]) begin
					waste_q <= waste_q + UW'(lastpos - hib);
				end
				if (last_k) begin
					result_q.ok           <= apply;
					result_q.alloc_start  <= (cmd_q.kind == KIND_ALLOC && found_q)
						? start_u_q[8:0] : 9'd0;
					result_q.free_units   <= new_w[0] ? free_q[9:0] : free_q[9:0] + CU_U[9:0];
					result_q.wasted_units <= (new_w[0] && !new_w[lastpos])
						? waste_q[8:0] + 9'(lastpos - hib) : waste_q[8:0];
				end
			end
			default: ;
		endcase
	end

	assign busy   = (state_q != ST_IDLE);
	assign done   = done_q;
	assign result = result_q;

endmodule

// File: hdl/cba_cell.sv
module cba_cell #(
	parameter int WIDTH = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             shift,
	input  logic [WIDTH-1:0] next_word,
	output logic [WIDTH-1:0] word
);

	logic [WIDTH-1:0] word_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			word_q <= '0;
		end else if (shift) begin
			word_q <= next_word;
		end
	end

	assign word = word_q;

endmodule
